### rtl/pnrf_pkg.sv
// ----------------------------------------------------------------------------
// pnrf_pkg
// Shared types, constants and helpers of the packed nibble rectangle fill
// engine: store geometry, request codes, register indexes and queue words.
// ----------------------------------------------------------------------------
package pnrf_pkg;

    // frame store geometry
    localparam int unsigned STORE_BYTES = 131072;
    localparam int unsigned MADDR_W     = $clog2(STORE_BYTES);
    localparam logic [31:0] STORE_LIMIT = 32'(STORE_BYTES);

    // command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // request codes
    localparam logic [1:0] REQ_FILL  = 2'd0;
    localparam logic [1:0] REQ_PIXEL = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BAND_TOP    = 2'd0;
    localparam logic [1:0] CFG_BAND_ROWS   = 2'd1;
    localparam logic [1:0] CFG_LINE_PIXELS = 2'd2;
    localparam logic [1:0] CFG_ROW_BYTES   = 2'd3;

    // nibble keep masks for read-modify-write
    localparam logic [7:0] NIB_LO_MASK = 8'h0F;
    localparam logic [7:0] NIB_HI_MASK = 8'hF0;

    typedef logic [MADDR_W-1:0] t_maddr;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_FILL = 2'd1,
        K_READ = 2'd2
    } t_kind;

    typedef struct packed {
        logic [11:0] band_top;
        logic [11:0] band_rows;
        logic [11:0] line_pixels;
        logic [11:0] row_bytes;
    } t_cfg;

    // one classified request, already clipped
    typedef struct packed {
        t_kind       kind;
        logic        empty;
        logic [3:0]  shade;
        logic [11:0] x0;
        logic [11:0] x1;
        logic [11:0] rows;
        logic [23:0] base;
        logic [16:0] read_addr;
    } t_cmd;

    function automatic t_maddr mem_index(input logic [31:0] addr);
        return addr[MADDR_W-1:0];
    endfunction

    function automatic logic in_store(input logic [31:0] addr);
        return addr < STORE_LIMIT;
    endfunction

endpackage

### rtl/pnrf_front.sv
// ----------------------------------------------------------------------------
// pnrf_front
// Request front end: takes one word, clips it against the band and the
// line, computes the first row's byte offset and hands a command to the queue.
// ----------------------------------------------------------------------------
module pnrf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pnrf_pkg::t_cfg        i_cfg,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic signed [15:0]    i_rect_width,
    input  logic signed [15:0]    i_rect_height,
    input  logic [3:0]            i_shade,
    input  logic [16:0]           i_read_addr,
    output logic                  o_push,
    output pnrf_pkg::t_cmd        o_cmd,
    input  logic                  i_q_full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_CLIP = 4'b0010,
        F_BASE = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;

    logic [1:0]         r_type;
    logic signed [15:0] r_px, r_py, r_w, r_h;
    logic [3:0]         r_shade;
    logic [16:0]        r_addr;
    logic [11:0]        r_yoff;
    pnrf_pkg::t_cmd     r_cmd;

    pnrf_pkg::t_cmd     n_cmd;
    logic [11:0]        n_yoff;

    logic [15:0]        sum_x, sum_y;
    logic signed [16:0] s_px, s_py, s_ex, s_ey, s_top, s_bot, s_lp;
    logic signed [16:0] s_x0, s_x1, s_y0, s_y1, s_fill_off, s_pix_off, s_fill_rows;
    logic               fill_empty, pix_in;

    assign o_in_ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_q_full;
    assign o_cmd      = r_cmd;

    // clipping in signed 17-bit, but the 16-bit edge sums r_px + r_w and r_py + r_h can wrap
    always_comb begin
        sum_x       = 16'(r_px + r_w);
        sum_y       = 16'(r_py + r_h);
        s_px        = r_px;
        s_py        = r_py;
        s_ex        = $signed(sum_x);
        s_ey        = $signed(sum_y);
        s_top       = $signed({5'd0, i_cfg.band_top});
        s_bot       = s_top + $signed({5'd0, i_cfg.band_rows});
        s_lp        = $signed({5'd0, i_cfg.line_pixels});
        s_x0        = (s_px < 17'sd0) ? 17'sd0 : s_px;
        s_x1        = (s_ex > s_lp) ? s_lp : s_ex;
        s_y0        = (s_py < s_top) ? s_top : s_py;
        s_y1        = (s_ey > s_bot) ? s_bot : s_ey;
        s_fill_off  = s_y0 - s_top;
        s_pix_off   = s_py - s_top;
        s_fill_rows = s_y1 - s_y0;
        fill_empty  = (s_x0 >= s_x1) || (s_y0 >= s_y1);
        pix_in      = (s_px >= 17'sd0) && (s_px < s_lp) && (s_py >= s_top) && (s_py < s_bot);

        n_cmd           = '0;
        n_cmd.shade     = r_shade;
        n_cmd.read_addr = r_addr;
        n_yoff          = '0;
        unique case (r_type)
            pnrf_pkg::REQ_FILL: begin
                n_cmd.kind  = pnrf_pkg::K_FILL;
                n_cmd.empty = fill_empty;
                n_cmd.x0    = s_x0[11:0];
                n_cmd.x1    = s_x1[11:0];
                n_cmd.rows  = s_fill_rows[11:0];
                n_yoff      = s_fill_off[11:0];
            end
            pnrf_pkg::REQ_PIXEL: begin
                // a pixel is a one-by-one rectangle
                n_cmd.kind  = pnrf_pkg::K_FILL;
                n_cmd.empty = !pix_in;
                n_cmd.x0    = s_px[11:0];
                n_cmd.x1    = s_px[11:0] + 12'd1;
                n_cmd.rows  = 12'd1;
                n_yoff      = s_pix_off[11:0];
            end
            pnrf_pkg::REQ_READ: begin
                n_cmd.kind  = pnrf_pkg::K_READ;
            end
            default: begin
                n_cmd.kind  = pnrf_pkg::K_NONE;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_in_valid) n_state = F_CLIP;
            F_CLIP:  n_state = F_BASE;
            F_BASE:  n_state = F_PUSH;
            F_PUSH:  if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_type  <= i_req_type;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_w     <= i_rect_width;
            r_h     <= i_rect_height;
            r_shade <= i_shade;
            r_addr  <= i_read_addr;
        end
        if (r_state == F_CLIP) begin
            r_cmd  <= n_cmd;
            r_yoff <= n_yoff;
        end
        if (r_state == F_BASE) begin
            r_cmd.base <= r_yoff * i_cfg.row_bytes;
        end
    end

endmodule

### rtl/pnrf_queue.sv
// ----------------------------------------------------------------------------
// pnrf_queue
// Short command queue that decouples the request front end from the
// store back end.
// ----------------------------------------------------------------------------
module pnrf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pnrf_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pnrf_pkg::t_cmd  o_cmd
);

    localparam logic [pnrf_pkg::QPTR_W:0] DEPTH_CNT = (pnrf_pkg::QPTR_W + 1)'(pnrf_pkg::QDEPTH);

    pnrf_pkg::t_cmd                r_slot [pnrf_pkg::QDEPTH];
    logic [pnrf_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [pnrf_pkg::QPTR_W:0]     r_count;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_cmd;
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT) else $error("queue count out of range");

endmodule

### rtl/pnrf_back.sv
// ----------------------------------------------------------------------------
// pnrf_back
// Store back end: owns the frame store, walks each clipped row writing
// whole bytes and doing nibble read-modify-write at odd edges, serves
// byte reads and registers one result word.
// ----------------------------------------------------------------------------
module pnrf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [11:0]     i_row_bytes,
    input  logic            i_q_valid,
    input  pnrf_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_read_data,
    output logic            o_nothing_drawn
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_SPAN = 6'b000010,
        B_NRD  = 6'b000100,
        B_NWR  = 6'b001000,
        B_RRD  = 6'b010000,
        B_RES  = 6'b100000
    } t_bstate;

    t_bstate r_state, n_state;

    pnrf_pkg::t_cmd r_cmd;
    logic [11:0]    r_col, n_col;
    logic [23:0]    r_base, n_base;
    logic [11:0]    r_rows, n_rows;
    logic [7:0]     r_mem_q;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_data;
    logic           r_out_empty;

    logic [7:0]     r_store [pnrf_pkg::STORE_BYTES];

    logic [31:0]    pix_addr, rd_addr32;
    logic [12:0]    col_p1;
    logic           span_end, nib_step, res_load;
    logic           mem_we, mem_re;
    pnrf_pkg::t_maddr mem_waddr, mem_raddr;
    logic [7:0]     mem_wdata, res_data;

    assign pix_addr  = 32'(r_base) + 32'(r_col[11:1]);
    assign rd_addr32 = 32'(r_cmd.read_addr);
    assign col_p1    = {1'b0, r_col} + 13'd1;
    assign span_end  = (r_col >= r_cmd.x1);
    // odd left edge, or a lone even column at the right edge
    assign nib_step  = r_col[0] || (col_p1 == {1'b0, r_cmd.x1});
    assign res_load  = (r_state == B_RES) && (!r_out_valid || i_out_ready);
    assign res_data  = (r_cmd.kind == pnrf_pkg::K_READ && pnrf_pkg::in_store(rd_addr32))
                       ? r_mem_q : 8'd0;

    assign o_pop           = (r_state == B_IDLE) && i_q_valid;
    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_nothing_drawn = r_out_empty;

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_base      = r_base;
        n_rows      = r_rows;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = pnrf_pkg::mem_index(pix_addr);
        mem_raddr   = pnrf_pkg::mem_index(pix_addr);
        mem_wdata   = {r_cmd.shade, r_cmd.shade};
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    n_col  = i_cmd.x0;
                    n_base = i_cmd.base;
                    n_rows = i_cmd.rows;
                    if (i_cmd.kind == pnrf_pkg::K_FILL && !i_cmd.empty) begin
                        n_state = B_SPAN;
                    end else if (i_cmd.kind == pnrf_pkg::K_READ) begin
                        n_state = B_RRD;
                    end else begin
                        n_state = B_RES;
                    end
                end
            end
            B_SPAN: begin
                if (span_end) begin
                    if (r_rows == 12'd1) begin
                        n_state = B_RES;
                    end else begin
                        n_base = r_base + 24'(i_row_bytes);
                        n_col  = r_cmd.x0;
                        n_rows = r_rows - 12'd1;
                    end
                end else if (nib_step) begin
                    n_state = B_NRD;
                end else begin
                    mem_we = pnrf_pkg::in_store(pix_addr);
                    n_col  = r_col + 12'd2;
                end
            end
            B_NRD: begin
                mem_re  = pnrf_pkg::in_store(pix_addr);
                n_state = B_NWR;
            end
            B_NWR: begin
                mem_we = pnrf_pkg::in_store(pix_addr);
                if (!r_col[0]) begin
                    mem_wdata = (r_mem_q & pnrf_pkg::NIB_LO_MASK) | {r_cmd.shade, 4'd0};
                end else begin
                    mem_wdata = (r_mem_q & pnrf_pkg::NIB_HI_MASK) | {4'd0, r_cmd.shade};
                end
                n_col   = r_col + 12'd1;
                n_state = B_SPAN;
            end
            B_RRD: begin
                mem_re    = pnrf_pkg::in_store(rd_addr32);
                mem_raddr = pnrf_pkg::mem_index(rd_addr32);
                n_state   = B_RES;
            end
            B_RES: begin
                if (res_load) begin
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col  <= n_col;
        r_base <= n_base;
        r_rows <= n_rows;
        if (o_pop) r_cmd <= i_cmd;
        if (res_load) begin
            r_out_data  <= res_data;
            r_out_empty <= r_cmd.empty;
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_store[mem_waddr] <= mem_wdata;
        if (mem_re) r_mem_q <= r_store[mem_raddr];
    end

    a_nwr_after_nrd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_NWR |-> $past(r_state) == B_NRD) else $error("nibble write without read");
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re)) else $error("store read and write in one cycle");
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_SPAN |-> r_col <= r_cmd.x1) else $error("column ran past right edge");
    a_rows_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SPAN || r_state == B_NRD || r_state == B_NWR) |-> r_rows != 12'd0)
        else $error("fill active with no rows left");

endmodule

### rtl/packed_nibble_rect_fill.sv
// ----------------------------------------------------------------------------
// packed_nibble_rect_fill
// Fill engine over one band of a 4-bit, two-pixels-per-byte framebuffer:
// fill rectangle, set pixel and read byte, one result word per request.
//
//   channel  direction  handshake                 payload
//   in       to block   i_in_valid / o_in_ready   req_type .. read_addr
//   out      from block o_out_valid / i_out_ready read_data, nothing_drawn
//   cfg      to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// The front takes one word at a time (capture, clip, row offset multiply,
// queue push) and takes no new word until it has pushed the last; a 4-entry
// queue feeds the back, which owns the store. A fill walks each row, writing
// interior pairs one store byte per cycle and a nibble edge as a read then a write.
// Reset (synchronous, active low) clears control and loads the register
// defaults; the store is not cleared. A stalled result leaves the front and
// queue running until the queue fills.
// ----------------------------------------------------------------------------
module packed_nibble_rect_fill (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_rect_width,
    input  logic signed [15:0] i_rect_height,
    input  logic [3:0]         i_shade,
    input  logic [16:0]        i_read_addr,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_read_data,
    output logic               o_nothing_drawn
);

    pnrf_pkg::t_cfg r_cfg;
    pnrf_pkg::t_cmd front_cmd, queue_cmd;
    logic           push, q_full, q_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_top    <= 12'd0;
            r_cfg.band_rows   <= 12'd256;
            r_cfg.line_pixels <= 12'd640;
            r_cfg.row_bytes   <= 12'd320;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pnrf_pkg::CFG_BAND_TOP:    r_cfg.band_top    <= i_cfg_data;
                pnrf_pkg::CFG_BAND_ROWS:   r_cfg.band_rows   <= i_cfg_data;
                pnrf_pkg::CFG_LINE_PIXELS: r_cfg.line_pixels <= i_cfg_data;
                pnrf_pkg::CFG_ROW_BYTES:   r_cfg.row_bytes   <= i_cfg_data;
                default:                   r_cfg             <= r_cfg;
            endcase
        end
    end

    pnrf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_shade       (i_shade),
        .i_read_addr   (i_read_addr),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_q_full      (q_full)
    );

    pnrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (queue_cmd)
    );

    pnrf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_row_bytes     (r_cfg.row_bytes),
        .i_q_valid       (q_valid),
        .i_cmd           (queue_cmd),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_data     (o_read_data),
        .o_nothing_drawn (o_nothing_drawn)
    );

endmodule
